// ===== hw/rtl/sorted_set_insert_delete_assert.svh =====
// Assertion macros for the sorted set block and its port checker.
// Included by the checker file; depends on nothing else.
`ifndef SORTED_SET_INSERT_DELETE_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SSID_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted set port check failed");

// Checked on every clock edge, reset included.
`define SSID_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sorted set port check failed");

`endif

// ===== hw/rtl/ssid_pkg.sv =====
// Shared types and constants for the sorted set block.
// Used by the cell, the top level and the port checker; no dependencies.
package ssid_pkg;

  localparam int SSID_CAPACITY = 64;
  localparam int KEY_W         = 32;
  localparam int SLOT_W        = 6;
  localparam int STATUS_W      = 3;
  localparam int HCOUNT_W      = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    logic [SLOT_W-1:0]       slot;
  } ssid_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HCOUNT_W-1:0]     held_count;
    logic signed [KEY_W-1:0] read_value;
  } ssid_out_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                    ins_ok;
    logic                    del_ok;
    logic signed [KEY_W-1:0] key;
    logic [SLOT_W-1:0]       slot;
  } ssid_ctl_t;

endpackage

// ===== hw/rtl/ssid_cell.sv =====
// One position of the sorted store: holds a key, compares it with the
// broadcast key and shifts with its neighbours. Depends on ssid_pkg.
module ssid_cell
  import ssid_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  ssid_ctl_t               ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic                    left_lt,
  input  logic signed [KEY_W-1:0] left_value,
  input  logic signed [KEY_W-1:0] right_value,
  output logic signed [KEY_W-1:0] value,
  output logic                    lt,
  output logic                    eq,
  output logic signed [KEY_W-1:0] rd_data
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic occupied;
  logic hit;

  assign occupied = IDX < count;
  assign lt       = occupied && (value < ctl.key);
  assign eq       = occupied && (value == ctl.key);
  assign hit      = ({26'd0, ctl.slot} == 32'(INDEX));
  assign rd_data  = hit ? value : '0;

  // Cells below the sorted position keep their key. Insert: the first
  // other cell gets the new key, others the left one; delete: the right.
  always_ff @(posedge clk) begin
    if (ctl.ins_ok && !lt) begin
      value <= left_lt ? ctl.key : left_value;
    end else if (ctl.del_ok && !lt) begin
      value <= right_value;
    end
  end

endmodule

// ===== hw/rtl/sorted_set_insert_delete.sv =====
// Top level of the sorted set: control, status and the row of cells.
// Depends on ssid_pkg and ssid_cell.
//
// Sorted set of distinct signed keys held in ascending order in a row of
// compare-and-shift cells. An item taken when start is high is answered
// by a single done strobe on the next cycle, and busy stays low, so items
// may be issued on every cycle. The result is held until the next item is
// taken, and the receiver cannot stall it. An insert, delete or read is
// settled in a single pass across all cells, so the longest path is one
// key compare per cell plus the found reduction.
// Only the first 64 positions can be read, as the slot field is six bits.
module sorted_set_insert_delete
  import ssid_pkg::*;
#(
  parameter int CAPACITY = SSID_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ssid_in_t  cmd,
  output logic      done,
  output ssid_out_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  ssid_ctl_t               ctl;
  logic                    accept;
  logic                    found;
  logic signed [KEY_W-1:0] rd_value;
  logic [STATUS_W-1:0]     status_next;
  logic signed [KEY_W-1:0] read_next;

  logic signed [KEY_W-1:0] value   [CAPACITY];
  logic signed [KEY_W-1:0] rd_data [CAPACITY];
  logic [CAPACITY-1:0]     lt;
  logic [CAPACITY-1:0]     eq;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign found  = |eq;

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | rd_data[i];
    end
  end

  always_comb begin
    ctl.key     = cmd.key;
    ctl.slot    = cmd.slot;
    ctl.ins_ok  = 1'b0;
    ctl.del_ok  = 1'b0;
    count_next  = count;
    status_next = ST_DONE;
    read_next   = '0;
    case (cmd.op)
      OP_INSERT: begin
        if (found) begin
          status_next = ST_DUP;
        end else if (count >= CAP) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins_ok = accept;
          count_next = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!found) begin
          status_next = ST_NOTFOUND;
        end else begin
          ctl.del_ok = accept;
          count_next = count - 1'b1;
        end
      end
      OP_READ: begin
        if (32'(cmd.slot) < 32'(count)) begin
          read_next = rd_value;
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_value;
    logic signed [KEY_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_value = '0;
    end else begin : g_inner
      assign left_lt    = lt[i-1];
      assign left_value = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_body
      assign right_value = value[i+1];
    end

    ssid_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (value[i]),
      .lt          (lt[i]),
      .eq          (eq[i]),
      .rd_data     (rd_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status     <= status_next;
      result.held_count <= HCOUNT_W'(count_next);
      result.read_value <= read_next;
    end
  end

endmodule

// ===== hw/rtl/ssid_checker.sv =====
// Port checker for the sorted set block, bound to its top level.
// Depends on ssid_pkg and sorted_set_insert_delete_assert.svh.
`include "sorted_set_insert_delete_assert.svh"

module ssid_checker
  import ssid_pkg::*;
#(
  parameter int CAPACITY = SSID_CAPACITY
) (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input ssid_in_t  cmd,
  input logic      done,
  input ssid_out_t result
);

  // Every accepted transaction is answered on the next cycle, and only then.
  `SSID_ASSERT(a_done_follows, (start && !busy) |=> done)
  `SSID_ASSERT(a_done_caused, done |-> $past(start && !busy))
  // A failed item reports no read data.
  `SSID_ASSERT(a_fail_no_data, (done && result.status != ST_DONE) |-> result.read_value == '0)
  // A full report means the store really holds its capacity.
  `SSID_ASSERT(a_full_count,
               (done && result.status == ST_FULL) |-> result.held_count == HCOUNT_W'(CAPACITY))
  `SSID_ASSERT_ALWAYS(a_no_done_in_reset, rst |=> !done)

endmodule

bind sorted_set_insert_delete ssid_checker #(.CAPACITY(CAPACITY)) u_ssid_checker (.*);
